### design/shg_pkg.sv
// Shared types and constants for the scrambled Halton generator.
// No dependencies.
package shg_pkg;

   localparam int DIM_W   = 3;   // dimension field width
   localparam int DGT_W   = 5;   // digit / permutation entry width
   localparam int IDX_W   = 6;   // digit position, covers up to 64 digits
   localparam int CLR_W   = 9;   // clearing sweep index, up to 512 entries
   localparam int WORD_W  = 32;
   localparam int DIV_STEPS = 4; // 8 quotient bits per step
   localparam int STEP_W  = 2;

   typedef enum logic [1:0] {
      FN_ADV  = 2'd0,
      FN_LEAP = 2'd1,
      FN_PERM = 2'd2,
      FN_LOAD = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_RD_DIGIT,
      OP_ADV_WR,
      OP_RD_PERM,
      OP_PERM_WR,
      OP_LD_INIT,
      OP_DIV_STEP,
      OP_LD_WR,
      OP_ACC_CLR,
      OP_SUM_LD,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [DIM_W-1:0] dim;
      logic [IDX_W-1:0] idx;
      logic [CLR_W-1:0] clr;
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic digit_top;   // digit read last cycle is base-1
      logic out_free;    // result register can take a beat
   } status_type;

   function automatic logic [DGT_W-1:0] prime_of(input logic [DIM_W-1:0] d);
      logic [DGT_W-1:0] p;
      case (d)
         3'd0: p = 5'd2;
         3'd1: p = 5'd3;
         3'd2: p = 5'd5;
         3'd3: p = 5'd7;
         3'd4: p = 5'd11;
         3'd5: p = 5'd13;
         3'd6: p = 5'd17;
         default: p = 5'd19;
      endcase
      return p;
   endfunction

endpackage

### design/shg_if.sv
// Request and response channel interfaces.
// Depends on shg_pkg.
interface shg_req_if import shg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        func;
   logic [DIM_W-1:0]  dim;
   logic [4:0]        entry_index;
   logic [4:0]        entry_value;
   logic [WORD_W-1:0] start_index;
   modport source (output valid, func, dim, entry_index, entry_value, start_index,
                   input ready);
   modport sink   (input valid, func, dim, entry_index, entry_value, start_index,
                   output ready);
endinterface

interface shg_rsp_if import shg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIM_W-1:0]  out_dim;
   logic [WORD_W-1:0] sample;
   logic              last;
   modport source (output valid, out_dim, sample, last, input ready);
   modport sink   (input valid, out_dim, sample, last, output ready);
endinterface

### design/shg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module shg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### design/shg_datapath.sv
// Datapath: digit and permutation memories, shared 8-bit-per-cycle divider,
// input latch and result register. Depends on shg_pkg and shg_ram.
module shg_datapath import shg_pkg::*; #(
   parameter int DIMS   = 8,
   parameter int DIGITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [4:0]        in_entry_index,
   input  logic [4:0]        in_entry_value,
   input  logic [WORD_W-1:0] in_start_index,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [DIM_W-1:0]  rsp_out_dim,
   output logic [WORD_W-1:0] rsp_sample,
   output logic              rsp_last
);
   localparam int DDEPTH = DIMS * DIGITS;
   localparam int PDEPTH = DIMS * 32;
   localparam int DA_W   = $clog2(DDEPTH);
   localparam int PA_W   = $clog2(PDEPTH);

   logic [4:0]        ei_ff, ev_ff;
   logic [WORD_W-1:0] start_ff;
   logic [WORD_W-1:0] dvd_ff, dvd_in;
   logic [DGT_W-1:0]  rem_ff, rem_in;
   logic              rsp_valid_ff;
   logic [DIM_W-1:0]  out_dim_ff;
   logic [WORD_W-1:0] sample_ff;
   logic              last_ff;

   logic [DGT_W-1:0]  base;
   logic [DGT_W-1:0]  digit_rd, perm_rd;
   logic              d_we, p_we;
   logic [DA_W-1:0]   d_addr, d_waddr;
   logic [PA_W-1:0]   p_waddr, p_raddr;
   logic [DGT_W-1:0]  d_wdata, p_wdata;
   logic              out_free;
   logic [WORD_W+DGT_W-1:0] div_res;

   // eight restoring division steps on a narrow remainder
   function automatic logic [WORD_W+DGT_W-1:0] div8(input logic [DGT_W-1:0] r,
                                                    input logic [WORD_W-1:0] q,
                                                    input logic [DGT_W-1:0] b);
      logic [DGT_W:0]    t;
      logic [WORD_W-1:0] qq;
      t  = {1'b0, r};
      qq = q;
      for (int i = 0; i < 8; i++) begin
         t  = {t[DGT_W-1:0], qq[WORD_W-1]};
         qq = {qq[WORD_W-2:0], 1'b0};
         if (t >= {1'b0, b}) begin
            t     = t - {1'b0, b};
            qq[0] = 1'b1;
         end
      end
      return {t[DGT_W-1:0], qq};
   endfunction

   assign base     = prime_of(cmd.dim);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign div_res  = div8(rem_ff, dvd_ff, base);
   assign d_addr   = DA_W'(int'(cmd.dim) * DIGITS + int'(cmd.idx));

   always_comb begin
      d_we    = 1'b0;
      d_waddr = d_addr;
      d_wdata = '0;
      p_we    = 1'b0;
      p_waddr = PA_W'(int'(cmd.dim) * 32 + int'(ei_ff));
      p_wdata = ev_ff;
      p_raddr = PA_W'(int'(cmd.dim) * 32 + int'(digit_rd));
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      case (cmd.op)
         OP_CLEAR: begin
            d_we    = int'(cmd.clr) < DDEPTH;
            d_waddr = cmd.clr[DA_W-1:0];
            p_we    = int'(cmd.clr) < PDEPTH;
            p_waddr = cmd.clr[PA_W-1:0];
            p_wdata = cmd.clr[DGT_W-1:0];
         end
         OP_ADV_WR: begin
            d_we    = 1'b1;
            d_wdata = status.digit_top ? '0 : digit_rd + 1'b1;
         end
         OP_PERM_WR: p_we = (ei_ff < base) && (ev_ff < base);
         OP_LD_INIT: begin
            dvd_in = start_ff - 1'b1;
            rem_in = '0;
         end
         OP_DIV_STEP: begin
            dvd_in = div_res[WORD_W-1:0];
            rem_in = div_res[WORD_W+DGT_W-1:WORD_W];
         end
         OP_LD_WR: begin
            d_we    = 1'b1;
            d_wdata = rem_ff;
            rem_in  = '0;
         end
         OP_ACC_CLR: dvd_in = '0;
         OP_SUM_LD:  rem_in = perm_rd;
         default: ;
      endcase
   end

   assign status.digit_top = (digit_rd == base - 1'b1);
   assign status.out_free  = out_free;

   shg_ram #(.WIDTH(DGT_W), .DEPTH(DDEPTH)) u_digits (
      .clock(clock), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
      .raddr(d_addr), .rdata(digit_rd)
   );

   shg_ram #(.WIDTH(DGT_W), .DEPTH(PDEPTH)) u_perm (
      .clock(clock), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
      .raddr(p_raddr), .rdata(perm_rd)
   );

   always_ff @(posedge clock) begin
      if (take) begin
         ei_ff    <= in_entry_index;
         ev_ff    <= in_entry_value;
         start_ff <= in_start_index;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (cmd.op == OP_EMIT && out_free) begin
         out_dim_ff <= cmd.dim;
         sample_ff  <= dvd_ff;
         last_ff    <= cmd.last;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_dim = out_dim_ff;
   assign rsp_sample  = sample_ff;
   assign rsp_last    = last_ff;
endmodule

### design/shg_ctrl.sv
// Controller: sequences clearing, start loads, permutation writes, digit
// walks and radical-inverse sums. Depends on shg_pkg.
module shg_ctrl import shg_pkg::*; #(
   parameter int DIMS   = 8,
   parameter int DIGITS = 32,
   parameter int LEAP   = 727
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_func,
   input  logic [DIM_W-1:0] req_dim,
   output cmd_type          cmd,
   input  status_type       status
);
   localparam int CLR_N = (DIMS * DIGITS > DIMS * 32) ? DIMS * DIGITS : DIMS * 32;
   localparam int LC_W  = $clog2(LEAP + 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_PERM, S_LD_INIT, S_LD_DIV, S_LD_WR,
      S_ADV_RD, S_ADV_WR, S_SUM_INIT, S_SUM_RDD, S_SUM_RDP,
      S_SUM_DIVLD, S_SUM_DIV, S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [DIM_W-1:0]  d_ff, d_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   logic [LC_W-1:0]   leap_ff, leap_in;

   localparam logic [DIM_W-1:0]  D_TOP = DIM_W'(DIMS - 1);
   localparam logic [IDX_W-1:0]  J_TOP = IDX_W'(DIGITS - 1);
   localparam logic [STEP_W-1:0] S_TOP = STEP_W'(DIV_STEPS - 1);

   always_comb begin
      state_in = state_ff;
      d_in     = d_ff;
      j_in     = j_ff;
      step_in  = step_ff;
      clr_in   = clr_ff;
      leap_in  = leap_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(CLR_N - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               d_in = '0;
               j_in = '0;
               leap_in = '0;
               case (func_type'(req_func))
                  FN_ADV:  state_in = S_ADV_RD;
                  FN_LEAP: begin
                     leap_in  = LC_W'(LEAP - 1);
                     state_in = S_ADV_RD;
                  end
                  FN_PERM: begin
                     d_in = req_dim;
                     if (int'(req_dim) < DIMS) state_in = S_PERM;
                  end
                  default: begin
                     d_in = req_dim;
                     if (int'(req_dim) < DIMS) state_in = S_LD_INIT;
                  end
               endcase
            end
         end
         S_PERM: state_in = S_IDLE;
         S_LD_INIT: begin
            step_in  = '0;
            state_in = S_LD_DIV;
         end
         S_LD_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == S_TOP) state_in = S_LD_WR;
         end
         S_LD_WR: begin
            step_in = '0;
            if (j_ff == J_TOP) begin
               state_in = S_IDLE;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_LD_DIV;
            end
         end
         S_ADV_RD: state_in = S_ADV_WR;
         S_ADV_WR: begin
            state_in = S_ADV_RD;
            if (status.digit_top && j_ff != J_TOP) begin
               j_in = j_ff + 1'b1;
            end else if (d_ff != D_TOP) begin
               d_in = d_ff + 1'b1;
               j_in = '0;
            end else if (leap_ff != '0) begin
               leap_in = leap_ff - 1'b1;
               d_in    = '0;
               j_in    = '0;
            end else begin
               d_in     = '0;
               state_in = S_SUM_INIT;
            end
         end
         S_SUM_INIT: begin
            j_in     = J_TOP;
            state_in = S_SUM_RDD;
         end
         S_SUM_RDD: state_in = S_SUM_RDP;
         S_SUM_RDP: state_in = S_SUM_DIVLD;
         S_SUM_DIVLD: begin
            step_in  = '0;
            state_in = S_SUM_DIV;
         end
         S_SUM_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == S_TOP) begin
               if (j_ff == '0) begin
                  state_in = S_EMIT;
               end else begin
                  j_in     = j_ff - 1'b1;
                  state_in = S_SUM_RDD;
               end
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               if (d_ff == D_TOP) begin
                  state_in = S_IDLE;
               end else begin
                  d_in     = d_ff + 1'b1;
                  state_in = S_SUM_INIT;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         d_ff     <= '0;
         j_ff     <= '0;
         step_ff  <= '0;
         clr_ff   <= '0;
         leap_ff  <= '0;
      end else begin
         state_ff <= state_in;
         d_ff     <= d_in;
         j_ff     <= j_in;
         step_ff  <= step_in;
         clr_ff   <= clr_in;
         leap_ff  <= leap_in;
      end
   end

   always_comb begin
      cmd.dim  = d_ff;
      cmd.idx  = j_ff;
      cmd.clr  = clr_ff;
      cmd.last = (d_ff == D_TOP);
      unique case (state_ff)
         S_CLEAR:              cmd.op = OP_CLEAR;
         S_PERM:               cmd.op = OP_PERM_WR;
         S_LD_INIT:            cmd.op = OP_LD_INIT;
         S_LD_DIV, S_SUM_DIV:  cmd.op = OP_DIV_STEP;
         S_LD_WR:              cmd.op = OP_LD_WR;
         S_ADV_RD, S_SUM_RDD:  cmd.op = OP_RD_DIGIT;
         S_ADV_WR:             cmd.op = OP_ADV_WR;
         S_SUM_INIT:           cmd.op = OP_ACC_CLR;
         S_SUM_RDP:            cmd.op = OP_RD_PERM;
         S_SUM_DIVLD:          cmd.op = OP_SUM_LD;
         S_EMIT:               cmd.op = OP_EMIT;
         default:              cmd.op = OP_NONE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

`ifndef SYNTHESIS
   a_adv_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && func_type'(req_func) == FN_ADV)
      |=> state_ff == S_ADV_RD)
      else $error("advance did not start a digit walk");

   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && status.out_free && d_ff == D_TOP)
      |=> state_ff == S_IDLE)
      else $error("last dimension emitted but not idle");

   a_sum_down: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM_DIV && step_ff == S_TOP && j_ff != '0)
      |=> (state_ff == S_SUM_RDD && j_ff == $past(j_ff) - 1'b1))
      else $error("sum did not step to next lower digit");
`endif
endmodule

### design/scrambled_halton_generator.sv
// Scrambled Halton generator, one digit counter per dimension in its prime base.
// Start load: an init step, then for each digit the divider steps and a digit write.
// Advance: an accept, a digit walk that reads and writes each touched digit per
// dimension, then per emitted dimension a sum on the shared 8-bit-per-cycle divider;
// a leap repeats the walk LEAP times. Permutation write: accept, then write.
// One item in flight at a time. Reset first clears max(DIMS*DIGITS, DIMS*32) entries.
module scrambled_halton_generator import shg_pkg::*; #(
   parameter int DIMS   = 8,
   parameter int DIGITS = 32,
   parameter int LEAP   = 727
) (
   input logic         clock,
   input logic         reset,
   shg_req_if.sink     req,
   shg_rsp_if.source   rsp
);
   cmd_type    cmd;
   status_type status;
   logic       take;

   assign take = req.valid && req.ready;

   shg_ctrl #(.DIMS(DIMS), .DIGITS(DIGITS), .LEAP(LEAP)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .req_func(req.func), .req_dim(req.dim),
      .cmd(cmd), .status(status)
   );

   shg_datapath #(.DIMS(DIMS), .DIGITS(DIGITS)) u_dp (
      .clock(clock), .reset(reset), .take(take),
      .in_entry_index(req.entry_index),
      .in_entry_value(req.entry_value), .in_start_index(req.start_index),
      .cmd(cmd), .status(status),
      .rsp_ready(rsp.ready), .rsp_valid(rsp.valid),
      .rsp_out_dim(rsp.out_dim), .rsp_sample(rsp.sample), .rsp_last(rsp.last)
   );
endmodule
